>>> design/pnm_image_stream_decoder_unit_defines.svh
// Assertion macros used by the decoder back end (pnm_back).
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef PNM_IMAGE_STREAM_DECODER_UNIT_DEFINES_SVH
`define PNM_IMAGE_STREAM_DECODER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PNM_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PNM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pnm_pkg.sv
// Package for the PNM stream decoder: codes, constants and shared types.
// Depends on nothing; pnm_front, pnm_back and the top level import it.
`default_nettype none
package pnm_pkg;

  localparam int DEF_MAX_DIMENSION = 65535;
  localparam int DEF_IN_DEPTH      = 2;
  localparam int DEF_OUT_DEPTH     = 4;

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_MAGIC   = 3'd1;
  localparam logic [2:0] ERR_FORMAT  = 3'd2;
  localparam logic [2:0] ERR_EARLY   = 3'd3;
  localparam logic [2:0] ERR_RANGE   = 3'd4;
  localparam logic [2:0] ERR_SAMPLE  = 3'd5;

  localparam logic [3:0] PH_MAGIC_P = 4'd0;
  localparam logic [3:0] PH_MAGIC_D = 4'd1;
  localparam logic [3:0] PH_WIDTH   = 4'd2;
  localparam logic [3:0] PH_HEIGHT  = 4'd3;
  localparam logic [3:0] PH_MAXVAL  = 4'd4;
  localparam logic [3:0] PH_SEP     = 4'd5;
  localparam logic [3:0] PH_PLAIN   = 4'd6;
  localparam logic [3:0] PH_RAW     = 4'd7;
  localparam logic [3:0] PH_DONE    = 4'd8;
  localparam logic [3:0] PH_ERROR   = 4'd9;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;

  localparam logic [16:0] ACC_CAP   = 17'h1ffff;
  localparam logic [31:0] ARGB_BLACK = 32'hff000000;
  localparam logic [31:0] ARGB_WHITE = 32'hffffffff;
  localparam logic [7:0]  ALPHA      = 8'hff;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       is_digit;
    logic       is_ws;
  } pnm_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] argb;
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  err;
    logic        last;
  } pnm_res_t;

endpackage
`default_nettype wire

>>> design/pnm_fifo.sv
// Small register FIFO with first-word fall-through output.
// Generic in width and depth; imports nothing.
`default_nettype none
module pnm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end
endmodule
`default_nettype wire

>>> design/pnm_front.sv
// Front end: accepts file bytes, classifies them and queues them.
// Depends on pnm_pkg and pnm_fifo.
`default_nettype none
module pnm_front import pnm_pkg::*; #(
  parameter int IN_DEPTH = DEF_IN_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_end_of_file,
  output logic            in_full,
  input  wire logic       item_pop,
  output pnm_item_t       item,
  output logic            item_empty
);
  pnm_item_t in_item;
  logic [$bits(pnm_item_t)-1:0] q_rdata;

  always_comb begin
    in_item.data     = in_data_byte;
    in_item.eof      = in_end_of_file;
    in_item.is_digit = (in_data_byte >= CH_ZERO) && (in_data_byte <= CH_NINE);
    in_item.is_ws    = (in_data_byte == CH_SPACE) || (in_data_byte == CH_TAB) ||
                       (in_data_byte == CH_LF) || (in_data_byte == CH_CR);
  end

  pnm_fifo #(.WIDTH($bits(pnm_item_t)), .DEPTH(IN_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (in_item),
    .full  (in_full),
    .pop   (item_pop),
    .rdata (q_rdata),
    .empty (item_empty)
  );

  assign item = pnm_item_t'(q_rdata);
endmodule
`default_nettype wire

>>> design/pnm_div.sv
// Restoring divider, one quotient bit per cycle, for sample rescaling.
// Depends on nothing.
`default_nettype none
module pnm_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [23:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             busy,
  output logic [7:0]       quotient
);
  localparam int DW = 24;
  localparam int CW = $clog2(DW);

  logic [DW-1:0] quo_r;
  logic [15:0]   rem_r, div_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [16:0]   rem_sh, rem_sub;
  logic          take;

  assign rem_sh  = {rem_r, quo_r[DW-1]};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign take    = (rem_sh >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], take};
      rem_r <= take ? rem_sub[15:0] : rem_sh[15:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r[7:0];
endmodule
`default_nettype wire

>>> design/pnm_back.sv
// Back end: header parser and sample sequencer, handling one byte at a time.
// Depends on pnm_pkg, pnm_div and the assertion macro header.
`default_nettype none
`include "pnm_image_stream_decoder_unit_defines.svh"
module pnm_back import pnm_pkg::*; #(
  parameter int MAX_DIMENSION = DEF_MAX_DIMENSION
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire pnm_item_t item,
  input  wire logic      item_empty,
  output logic           item_pop,
  output logic           res_push,
  output pnm_res_t       res,
  input  wire logic      res_full
);
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DISP = 4'd1;
  localparam logic [3:0] ST_TAIL = 4'd2;
  localparam logic [3:0] ST_SAMP = 4'd3;
  localparam logic [3:0] ST_DIVW = 4'd4;
  localparam logic [3:0] ST_SCL  = 4'd5;
  localparam logic [3:0] ST_PIX  = 4'd6;
  localparam logic [3:0] ST_CPL  = 4'd7;
  localparam logic [3:0] ST_BIT  = 4'd8;
  localparam logic [3:0] ST_EOF1 = 4'd9;
  localparam logic [3:0] ST_EOF2 = 4'd10;
  localparam logic [3:0] ST_FIN  = 4'd11;

  localparam logic [1:0] CONT_TAIL = 2'd0;
  localparam logic [1:0] CONT_EOF1 = 2'd1;
  localparam logic [1:0] CONT_EOF2 = 2'd2;
  localparam logic [1:0] CONT_BIT  = 2'd3;

  logic [3:0]  state_r, state_nxt, phase_r, phase_nxt, bit_r, bit_nxt;
  logic [1:0]  fmt_r, fmt_nxt, ch_r, ch_nxt, cont_r, cont_nxt;
  logic        plain_r, plain_nxt, cmt_r, cmt_nxt, dseen_r, dseen_nxt;
  logic [16:0] acc_r, acc_nxt, samp_r, samp_nxt;
  logic [15:0] w_r, w_nxt, h_r, h_nxt, max_r, max_nxt, col_r, col_nxt, row_r, row_nxt;
  logic [7:0]  red_r, red_nxt, grn_r, grn_nxt, hold_r, hold_nxt;
  logic        bph_r, bph_nxt, wrap_r, wrap_nxt;
  pnm_item_t   cur_r, cur_nxt;
  logic [31:0] pix_r, pix_nxt;
  logic        pend_v_r, pend_v_nxt;
  pnm_res_t    pend_r, pend_nxt;

  logic        go, em_v, do_fin, div_start, div_busy, tok_phase, big;
  pnm_res_t    em;
  logic [3:0]  cont_state;
  logic [20:0] acc_mul;
  logic [2:0]  mag_k;
  logic [7:0]  quo, b;
  logic [16:0] col_inc, row_inc;
  logic [23:0] div_num;

  assign go        = !res_full;
  assign b         = cur_r.data;
  assign tok_phase = (phase_r == PH_WIDTH) || (phase_r == PH_HEIGHT) ||
                     (phase_r == PH_MAXVAL) || (phase_r == PH_PLAIN);
  assign acc_mul   = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {17'b0, b[3:0]};
  assign mag_k     = 3'(b - CH_ONE);
  assign big       = acc_r[16] || ({15'b0, acc_r} > 32'(MAX_DIMENSION));
  assign col_inc   = {1'b0, col_r} + 17'd1;
  assign row_inc   = {1'b0, row_r} + 17'd1;
  assign div_num   = {samp_r[15:0], 8'b0} - {8'b0, samp_r[15:0]} + {9'b0, max_r[15:1]};

  always_comb begin
    case (cont_r)
      CONT_TAIL: cont_state = ST_TAIL;
      CONT_EOF1: cont_state = ST_EOF1;
      CONT_EOF2: cont_state = ST_EOF2;
      default:   cont_state = ST_BIT;
    endcase
  end

  pnm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (max_r),
    .busy     (div_busy),
    .quotient (quo)
  );

  always_comb begin
    state_nxt = state_r;  phase_nxt = phase_r;  bit_nxt = bit_r;
    fmt_nxt = fmt_r;      ch_nxt = ch_r;        cont_nxt = cont_r;
    plain_nxt = plain_r;  cmt_nxt = cmt_r;      dseen_nxt = dseen_r;
    acc_nxt = acc_r;      samp_nxt = samp_r;    w_nxt = w_r;
    h_nxt = h_r;          max_nxt = max_r;      col_nxt = col_r;
    row_nxt = row_r;      red_nxt = red_r;      grn_nxt = grn_r;
    hold_nxt = hold_r;    bph_nxt = bph_r;      wrap_nxt = wrap_r;
    cur_nxt = cur_r;      pix_nxt = pix_r;
    em = '0;
    em_v = 1'b0;
    do_fin = 1'b0;
    div_start = 1'b0;
    item_pop = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (!item_empty) begin
          item_pop  = go;
          cur_nxt   = item;
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        state_nxt = ST_EOF1;
        case (phase_r)
          PH_MAGIC_P: begin
            if (b == CH_P) begin
              phase_nxt = PH_MAGIC_D;
            end else begin
              em_v = 1'b1; em.kind = KIND_ERROR; em.err = ERR_MAGIC;
              phase_nxt = PH_ERROR;
            end
          end
          PH_MAGIC_D: begin
            if (b >= CH_ONE && b <= CH_SIX) begin
              plain_nxt = (mag_k < 3'd3);
              fmt_nxt   = (mag_k < 3'd3) ? mag_k[1:0] : 2'(mag_k - 3'd3);
              phase_nxt = PH_WIDTH;
            end else begin
              em_v = 1'b1; em.kind = KIND_ERROR; em.err = ERR_MAGIC;
              phase_nxt = PH_ERROR;
            end
          end
          PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_PLAIN: begin
            if (cmt_r) begin
              if (b == CH_LF || b == CH_CR) begin
                cmt_nxt = 1'b0;
              end
            end else if (cur_r.is_digit) begin
              if (phase_r == PH_PLAIN && fmt_r == 2'd0) begin
                samp_nxt  = {13'b0, b[3:0]};
                cont_nxt  = CONT_EOF1;
                state_nxt = ST_SAMP;
              end else begin
                acc_nxt   = (acc_mul > {4'b0, ACC_CAP}) ? ACC_CAP : acc_mul[16:0];
                dseen_nxt = 1'b1;
              end
            end else if (dseen_r) begin
              if (phase_r == PH_PLAIN) begin
                samp_nxt  = acc_r;
                acc_nxt   = '0;
                dseen_nxt = 1'b0;
                cont_nxt  = CONT_TAIL;
                state_nxt = ST_SAMP;
              end else begin
                do_fin    = 1'b1;
                state_nxt = ST_TAIL;
              end
            end else begin
              state_nxt = ST_TAIL;
            end
          end
          PH_SEP: begin
            state_nxt = ST_TAIL;
          end
          PH_RAW: begin
            if (fmt_r == 2'd0) begin
              bit_nxt   = '0;
              wrap_nxt  = 1'b0;
              state_nxt = ST_BIT;
            end else if (max_r > 16'd255) begin
              if (!bph_r) begin
                hold_nxt = b;
                bph_nxt  = 1'b1;
              end else begin
                samp_nxt  = {1'b0, hold_r, b};
                bph_nxt   = 1'b0;
                cont_nxt  = CONT_EOF1;
                state_nxt = ST_SAMP;
              end
            end else begin
              samp_nxt  = {9'b0, b};
              cont_nxt  = CONT_EOF1;
              state_nxt = ST_SAMP;
            end
          end
          default: begin
            state_nxt = ST_EOF1;
          end
        endcase
      end
      ST_TAIL: begin
        state_nxt = ST_EOF1;
        if (phase_r == PH_SEP) begin
          if (cur_r.is_ws) begin
            em_v = 1'b1; em.kind = KIND_HEADER; em.width = w_r; em.height = h_r;
            phase_nxt = PH_RAW;
          end else begin
            em_v = 1'b1; em.kind = KIND_ERROR; em.err = ERR_FORMAT;
            phase_nxt = PH_ERROR;
          end
        end else if (tok_phase) begin
          if (b == CH_HASH) begin
            cmt_nxt = 1'b1;
          end else if (!cur_r.is_ws) begin
            em_v = 1'b1; em.kind = KIND_ERROR; em.err = ERR_FORMAT;
            phase_nxt = PH_ERROR;
          end
        end
      end
      ST_SAMP: begin
        if (samp_r > {1'b0, max_r}) begin
          em_v = 1'b1; em.kind = KIND_ERROR; em.err = ERR_SAMPLE;
          phase_nxt = PH_ERROR;
          state_nxt = cont_state;
        end else if (fmt_r == 2'd0) begin
          pix_nxt   = (samp_r != '0) ? ARGB_BLACK : ARGB_WHITE;
          state_nxt = ST_PIX;
        end else begin
          div_start = go;
          state_nxt = ST_DIVW;
        end
      end
      ST_DIVW: begin
        if (!div_busy) begin
          state_nxt = ST_SCL;
        end
      end
      ST_SCL: begin
        if (fmt_r == 2'd1) begin
          pix_nxt   = {ALPHA, quo, quo, quo};
          state_nxt = ST_PIX;
        end else if (ch_r == 2'd0) begin
          red_nxt   = quo;
          ch_nxt    = 2'd1;
          state_nxt = cont_state;
        end else if (ch_r == 2'd1) begin
          grn_nxt   = quo;
          ch_nxt    = 2'd2;
          state_nxt = cont_state;
        end else begin
          ch_nxt    = 2'd0;
          pix_nxt   = {ALPHA, red_r, grn_r, quo};
          state_nxt = ST_PIX;
        end
      end
      ST_PIX: begin
        em_v = 1'b1; em.kind = KIND_PIXEL; em.argb = pix_r;
        state_nxt = cont_state;
        if (col_inc >= {1'b0, w_r}) begin
          col_nxt  = '0;
          row_nxt  = row_inc[15:0];
          wrap_nxt = 1'b1;
          if (row_inc >= {1'b0, h_r}) begin
            state_nxt = ST_CPL;
          end
        end else begin
          col_nxt  = col_inc[15:0];
          wrap_nxt = 1'b0;
        end
      end
      ST_CPL: begin
        em_v = 1'b1; em.kind = KIND_DONE;
        phase_nxt = PH_DONE;
        state_nxt = cont_state;
      end
      ST_BIT: begin
        if (phase_r != PH_RAW || bit_r == 4'd8 || (bit_r != '0 && wrap_r)) begin
          state_nxt = ST_EOF1;
        end else begin
          pix_nxt   = b[3'(3'd7 - bit_r[2:0])] ? ARGB_BLACK : ARGB_WHITE;
          bit_nxt   = bit_r + 4'd1;
          cont_nxt  = CONT_BIT;
          state_nxt = ST_PIX;
        end
      end
      ST_EOF1: begin
        if (!cur_r.eof) begin
          state_nxt = ST_FIN;
        end else if (dseen_r && tok_phase) begin
          if (phase_r == PH_PLAIN) begin
            samp_nxt  = acc_r;
            acc_nxt   = '0;
            dseen_nxt = 1'b0;
            cont_nxt  = CONT_EOF2;
            state_nxt = ST_SAMP;
          end else begin
            do_fin    = 1'b1;
            state_nxt = ST_EOF2;
          end
        end else begin
          state_nxt = ST_EOF2;
        end
      end
      ST_EOF2: begin
        if (phase_r <= PH_MAGIC_D) begin
          em_v = 1'b1; em.kind = KIND_ERROR; em.err = ERR_MAGIC;
        end else if (phase_r != PH_DONE && phase_r != PH_ERROR) begin
          em_v = 1'b1; em.kind = KIND_ERROR; em.err = ERR_EARLY;
        end
        phase_nxt = PH_MAGIC_P;
        fmt_nxt = '0;   plain_nxt = 1'b0; cmt_nxt = 1'b0; dseen_nxt = 1'b0;
        acc_nxt = '0;   w_nxt = '0;       h_nxt = '0;     max_nxt = '0;
        col_nxt = '0;   row_nxt = '0;     ch_nxt = '0;    red_nxt = '0;
        grn_nxt = '0;   hold_nxt = '0;    bph_nxt = 1'b0;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (do_fin) begin
      acc_nxt   = '0;
      dseen_nxt = 1'b0;
      case (phase_r)
        PH_WIDTH, PH_HEIGHT: begin
          if (acc_r == '0) begin
            em_v = 1'b1; em.kind = KIND_ERROR; em.err = ERR_FORMAT;
            phase_nxt = PH_ERROR;
          end else if (big) begin
            em_v = 1'b1; em.kind = KIND_ERROR; em.err = ERR_RANGE;
            phase_nxt = PH_ERROR;
          end else if (phase_r == PH_WIDTH) begin
            w_nxt     = acc_r[15:0];
            phase_nxt = PH_HEIGHT;
          end else begin
            h_nxt = acc_r[15:0];
            if (fmt_r == 2'd0) begin
              max_nxt = 16'd1;
              col_nxt = '0; row_nxt = '0; ch_nxt = '0; bph_nxt = 1'b0;
              if (plain_r) begin
                em_v = 1'b1; em.kind = KIND_HEADER; em.width = w_r;
                em.height = acc_r[15:0];
                phase_nxt = PH_PLAIN;
              end else begin
                phase_nxt = PH_SEP;
              end
            end else begin
              phase_nxt = PH_MAXVAL;
            end
          end
        end
        PH_MAXVAL: begin
          if (acc_r == '0) begin
            em_v = 1'b1; em.kind = KIND_ERROR; em.err = ERR_FORMAT;
            phase_nxt = PH_ERROR;
          end else if (acc_r[16]) begin
            em_v = 1'b1; em.kind = KIND_ERROR; em.err = ERR_RANGE;
            phase_nxt = PH_ERROR;
          end else begin
            max_nxt = acc_r[15:0];
            col_nxt = '0; row_nxt = '0; ch_nxt = '0; bph_nxt = 1'b0;
            if (plain_r) begin
              em_v = 1'b1; em.kind = KIND_HEADER; em.width = w_r; em.height = h_r;
              phase_nxt = PH_PLAIN;
            end else begin
              phase_nxt = PH_SEP;
            end
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end

    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    res_push   = 1'b0;
    res        = pend_r;
    res.last   = (state_r == ST_FIN);
    if (em_v) begin
      res_push   = go && pend_v_r;
      pend_nxt   = em;
      pend_v_nxt = 1'b1;
    end else if (state_r == ST_FIN) begin
      res_push   = go && pend_v_r;
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      phase_r  <= PH_MAGIC_P;
      fmt_r    <= '0;
      plain_r  <= 1'b0;
      cmt_r    <= 1'b0;
      dseen_r  <= 1'b0;
      acc_r    <= '0;
      w_r      <= '0;
      h_r      <= '0;
      max_r    <= '0;
      col_r    <= '0;
      row_r    <= '0;
      ch_r     <= '0;
      red_r    <= '0;
      grn_r    <= '0;
      hold_r   <= '0;
      bph_r    <= 1'b0;
      pend_v_r <= 1'b0;
    end else if (go) begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      fmt_r    <= fmt_nxt;
      plain_r  <= plain_nxt;
      cmt_r    <= cmt_nxt;
      dseen_r  <= dseen_nxt;
      acc_r    <= acc_nxt;
      w_r      <= w_nxt;
      h_r      <= h_nxt;
      max_r    <= max_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      ch_r     <= ch_nxt;
      red_r    <= red_nxt;
      grn_r    <= grn_nxt;
      hold_r   <= hold_nxt;
      bph_r    <= bph_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      cur_r  <= cur_nxt;
      samp_r <= samp_nxt;
      pix_r  <= pix_nxt;
      bit_r  <= bit_nxt;
      wrap_r <= wrap_nxt;
      cont_r <= cont_nxt;
      pend_r <= pend_nxt;
    end
  end

  `PNM_ASSERT_IMPL(a_idle_no_pending, state_r == ST_IDLE, !pend_v_r, "result pending while idle")
  `PNM_ASSERT_IMPL(a_div_only_waiting, div_busy, state_r == ST_DIVW, "divider busy outside wait")
  `PNM_ASSERT_IMPL(a_pix_phase, state_r == ST_PIX,
    phase_r == PH_PLAIN || phase_r == PH_RAW, "pixel outside image data")
  `PNM_ASSERT_NEXT(a_fin_to_idle, state_r == ST_FIN && go, state_r == ST_IDLE,
    "transaction end did not return to idle")
endmodule
`default_nettype wire

>>> design/pnm_image_stream_decoder_unit.sv
// PNM stream decoder top level: byte queue, decoder core, result queue.
// Use: push file bytes on the in_ channel (a transaction is in_push with in_full low),
// marking the last byte of a file with in_end_of_file. Results come out in order on
// the out_ channel while out_empty is low; a transaction completes with out_pop high.
// Each byte yields zero to nine results; last_of_run marks the final one of a byte.
// Processing: a byte passes through the byte queue, then the core handles it alone,
// taking no new byte until it is through with the last. A byte that completes a gray or
// color sample adds rescaling (a start, 24 serial divider steps and a handoff).
// A raw bitmap byte steps through the ST_BIT and ST_PIX states for each pixel it
// expands to, up to eight pixels per byte.
// Reset (rst_n low, synchronous) empties both queues and returns the parser to
// expecting a new file. The end-of-file byte also returns it to that state.
// When the receiver stalls, the result queue fills, the core holds, and the byte
// queue fills until in_full rises; nothing is lost.
// Depends on pnm_pkg, pnm_front, pnm_back and pnm_fifo.
`default_nettype none
module pnm_image_stream_decoder_unit import pnm_pkg::*; #(
  parameter int MAX_DIMENSION = DEF_MAX_DIMENSION,
  parameter int IN_DEPTH      = DEF_IN_DEPTH,
  parameter int OUT_DEPTH     = DEF_OUT_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_file,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [1:0]       out_kind,
  output logic [31:0]      out_argb,
  output logic [15:0]      out_image_width_out,
  output logic [15:0]      out_image_height_out,
  output logic [2:0]       out_error_code,
  output logic             out_last_of_run
);
  pnm_item_t item;
  logic      item_empty, item_pop, res_push, res_full;
  pnm_res_t  res, res_head;
  logic [$bits(pnm_res_t)-1:0] q_rdata;

  pnm_front #(.IN_DEPTH(IN_DEPTH)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_data_byte   (in_data_byte),
    .in_end_of_file (in_end_of_file),
    .in_full        (in_full),
    .item_pop       (item_pop),
    .item           (item),
    .item_empty     (item_empty)
  );

  pnm_back #(.MAX_DIMENSION(MAX_DIMENSION)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_empty (item_empty),
    .item_pop   (item_pop),
    .res_push   (res_push),
    .res        (res),
    .res_full   (res_full)
  );

  pnm_fifo #(.WIDTH($bits(pnm_res_t)), .DEPTH(OUT_DEPTH)) u_out_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (q_rdata),
    .empty (out_empty)
  );

  assign res_head             = pnm_res_t'(q_rdata);
  assign out_kind             = res_head.kind;
  assign out_argb             = res_head.argb;
  assign out_image_width_out  = res_head.width;
  assign out_image_height_out = res_head.height;
  assign out_error_code       = res_head.err;
  assign out_last_of_run      = res_head.last;
endmodule
`default_nettype wire
